/* rtl/fully_associative_lru_cache_sim_core_assert.svh */
// assertion macros for the lru cache core checker
// each macro wraps a clocked property, disabled during reset
`ifndef FULLY_ASSOCIATIVE_LRU_CACHE_SIM_CORE_ASSERT_SVH
`define FULLY_ASSOCIATIVE_LRU_CACHE_SIM_CORE_ASSERT_SVH

// implication checked at every rising edge of clock
`define FALRU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same, for a property whose post must hold in the cycle after its pre
`define FALRU_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/falru_pkg.sv */
// shared types and constants of the fully associative lru cache core
// no dependencies
`default_nettype none

package falru_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int PAGE_W  = 32;
   localparam int USE_W   = 31;
   localparam int STAMP_W = 48;
   localparam int SLOT_W  = 8;
   localparam int FILL_W  = 9;

   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
   localparam logic [USE_W-1:0]   USE_MAX   = '1;

   typedef struct packed {
      logic [PAGE_W-1:0]  tag;
      logic [USE_W-1:0]   count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SEND
   } state_type;

endpackage

`default_nettype wire

/* rtl/fully_associative_lru_cache_sim_core.sv */
// fully associative lru page cache, one entry memory swept per transaction
// steps per transaction: accept in idle, sweep the occupied entries in scan, write the entry in update,
// then load the result in send when the result register is free
// one transaction at a time, set by the single read port sweeping all occupied entries
// reset clears fill level, access clock and totals; entry memory is not cleared
`default_nettype none

module fully_associative_lru_cache_sim_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_page,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_hit,
   output logic [7:0]       rsp_slot,
   output logic [30:0]      rsp_use_count,
   output logic [47:0]      rsp_hit_total,
   output logic [47:0]      rsp_miss_total,
   output logic [8:0]       rsp_filled
);

   localparam int IDX_W   = falru_pkg::IDX_W;
   localparam int CNT_W   = falru_pkg::CNT_W;
   localparam int STAMP_W = falru_pkg::STAMP_W;
   localparam int USE_W   = falru_pkg::USE_W;
   localparam int PAGE_W  = falru_pkg::PAGE_W;

   falru_pkg::state_type state_ff, state_in;

   // entry memory
   falru_pkg::entry_type mem [falru_pkg::ENTRIES];
   falru_pkg::entry_type rd_data_ff;
   falru_pkg::entry_type wr_data;
   logic                 mem_re, mem_we;
   logic [IDX_W-1:0]     wr_addr;

   // sweep control
   logic [CNT_W-1:0]     issue_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;

   // per transaction scan results
   logic [PAGE_W-1:0]    page_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     match_ff;
   logic [USE_W-1:0]     match_cnt_ff;
   logic                 first_ff;
   logic [STAMP_W-1:0]   oldest_ff;
   logic [IDX_W-1:0]     victim_ff;

   // result of the update step
   logic [IDX_W-1:0]     where_ff;
   logic [USE_W-1:0]     use_ff;

   // architectural state
   logic [CNT_W-1:0]     fill_ff;
   logic [STAMP_W-1:0]   clock_ff;
   logic [STAMP_W-1:0]   hits_ff;
   logic [STAMP_W-1:0]   misses_ff;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [7:0]           rsp_slot_ff;
   logic [30:0]          rsp_use_ff;
   logic [47:0]          rsp_hits_ff;
   logic [47:0]          rsp_misses_ff;
   logic [8:0]           rsp_filled_ff;

   logic                 accept;
   logic                 load_rsp;
   logic                 full;
   logic [IDX_W-1:0]     where_sel;
   logic [USE_W-1:0]     use_sel;

   assign accept    = req_valid && (state_ff == falru_pkg::ST_IDLE);
   assign full      = (fill_ff == CNT_W'(falru_pkg::ENTRIES));

   always_comb begin
      if (found_ff) begin
         where_sel = match_ff;
         use_sel   = (match_cnt_ff == falru_pkg::USE_MAX) ? match_cnt_ff
                                                          : match_cnt_ff + USE_W'(1);
      end else begin
         where_sel = full ? victim_ff : fill_ff[IDX_W-1:0];
         use_sel   = USE_W'(1);
      end
   end

   assign wr_addr       = where_sel;
   assign wr_data.tag   = page_ff;
   assign wr_data.count = use_sel;
   assign wr_data.stamp = clock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= falru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mem_re   = 1'b0;
      mem_we   = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         falru_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = falru_pkg::ST_SCAN;
            end
         end
         falru_pkg::ST_SCAN: begin
            // only slots below the fill level hold data
            mem_re = (issue_ff < fill_ff);
            if (!mem_re && !rd_vld_ff) begin
               state_in = falru_pkg::ST_UPDATE;
            end
         end
         falru_pkg::ST_UPDATE: begin
            mem_we   = 1'b1;
            state_in = falru_pkg::ST_SEND;
         end
         falru_pkg::ST_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = falru_pkg::ST_IDLE;
            end
         end
         default: state_in = falru_pkg::ST_IDLE;
      endcase
   end

   // memory: one write port, one registered read port; the write of a
   // transaction lands before the next sweep starts, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= issue_ff[IDX_W-1:0];
      if (accept) begin
         page_ff  <= req_page;
         issue_ff <= '0;
         found_ff <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         if (mem_re) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         if (rd_vld_ff) begin
            // lowest matching slot wins
            if (!found_ff && (rd_data_ff.tag == page_ff)) begin
               found_ff     <= 1'b1;
               match_ff     <= rd_idx_ff;
               match_cnt_ff <= rd_data_ff.count;
            end
            // strict compare keeps the lowest slot on stamp ties
            if (first_ff || (rd_data_ff.stamp < oldest_ff)) begin
               first_ff  <= 1'b0;
               oldest_ff <= rd_data_ff.stamp;
               victim_ff <= rd_idx_ff;
            end
         end
      end
      if (mem_we) begin
         where_ff <= where_sel;
         use_ff   <= use_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         clock_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else begin
         if (accept && (clock_ff != falru_pkg::STAMP_MAX)) begin
            clock_ff <= clock_ff + STAMP_W'(1);
         end
         if (mem_we) begin
            if (found_ff) begin
               if (hits_ff != falru_pkg::STAMP_MAX) begin
                  hits_ff <= hits_ff + STAMP_W'(1);
               end
            end else begin
               if (misses_ff != falru_pkg::STAMP_MAX) begin
                  misses_ff <= misses_ff + STAMP_W'(1);
               end
               if (!full) begin
                  fill_ff <= fill_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_hit_ff    <= found_ff;
         rsp_slot_ff   <= 8'(where_ff);
         rsp_use_ff    <= use_ff;
         rsp_hits_ff   <= hits_ff;
         rsp_misses_ff <= misses_ff;
         rsp_filled_ff <= 9'(fill_ff);
      end
   end

   assign req_stall      = (state_ff != falru_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_use_count  = rsp_use_ff;
   assign rsp_hit_total  = rsp_hits_ff;
   assign rsp_miss_total = rsp_misses_ff;
   assign rsp_filled     = rsp_filled_ff;

endmodule

`default_nettype wire

/* rtl/falru_chk.sv */
// port level checker for the lru cache core, bound to the top level
// depends on fully_associative_lru_cache_sim_core_assert.svh
`default_nettype none

`include "fully_associative_lru_cache_sim_core_assert.svh"

module falru_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_hit,
   input wire logic [30:0] rsp_use_count,
   input wire logic [47:0] rsp_hit_total,
   input wire logic [47:0] rsp_miss_total
);

   // a stalled result transaction keeps its totals
   `FALRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit_total) && $stable(rsp_miss_total), "stalled result changed")

   // a freshly filled or replaced entry starts counting at one
   `FALRU_ASSERT(a_miss_count, !(rsp_valid && !rsp_hit) || (rsp_use_count == 31'd1), "miss count not one")

   // a hit entry was counted at least once before
   `FALRU_ASSERT(a_hit_count, !(rsp_valid && rsp_hit) || (rsp_use_count > 31'd1), "hit count too low")

   // one transaction at a time: input stalls right after an accept
   `FALRU_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall, "no stall after accept")

endmodule

bind fully_associative_lru_cache_sim_core falru_chk u_falru_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit        (rsp_hit),
   .rsp_use_count  (rsp_use_count),
   .rsp_hit_total  (rsp_hit_total),
   .rsp_miss_total (rsp_miss_total)
);

`default_nettype wire

/* tb/fully_associative_lru_cache_sim_core_tb.sv */
// self-checking testbench for the fully associative lru page cache core
// depends on falru_pkg and fully_associative_lru_cache_sim_core; predicts each lookup in a class
`default_nettype none

module fully_associative_lru_cache_sim_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = falru_pkg::ENTRIES;
   localparam int PAGE_W  = falru_pkg::PAGE_W;
   localparam int USE_W   = falru_pkg::USE_W;
   localparam int STAMP_W = falru_pkg::STAMP_W;
   localparam int SLOT_W  = falru_pkg::SLOT_W;
   localparam int FILL_W  = falru_pkg::FILL_W;

   localparam int DIRECTED_COUNT = 20;
   localparam int RANDOM_ITEMS   = 1850;
   localparam int POOL_SIZE      = 512;
   localparam int HOT_SPAN       = 48;
   localparam int SETTLE_CYCLES  = ENTRIES + 40;

   typedef struct {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [USE_W-1:0]   use_count;
      logic [STAMP_W-1:0] hit_total;
      logic [STAMP_W-1:0] miss_total;
      logic [FILL_W-1:0]  filled;
   } lookup_result_type;

   // mirror of the cache table plus the queue of lookups still owed by the block
   class lru_tracker_type;
      logic [PAGE_W-1:0]  tags   [ENTRIES];
      logic [USE_W-1:0]   counts [ENTRIES];
      logic [STAMP_W-1:0] stamps [ENTRIES];
      int                 fill;
      logic [STAMP_W-1:0] access_now;
      logic [STAMP_W-1:0] hits;
      logic [STAMP_W-1:0] misses;
      lookup_result_type  pending_lookups [$];
      int                 errors;

      function new();
         fill       = 0;
         access_now = '0;
         hits       = '0;
         misses     = '0;
         errors     = 0;
      endfunction

      function logic [STAMP_W-1:0] bump48(logic [STAMP_W-1:0] v);
         return (v == falru_pkg::STAMP_MAX) ? v : v + STAMP_W'(1);
      endfunction

      function int outstanding();
         return pending_lookups.size();
      endfunction

      function void note_access(logic [PAGE_W-1:0] page);
         int                n;
         int                way;
         bit                found;
         lookup_result_type r;
         n     = (fill > ENTRIES) ? ENTRIES : fill;
         way   = 0;
         found = 1'b0;
         access_now = bump48(access_now);
         for (int i = 0; i < n; i++) begin
            if (!found && tags[i] == page) begin
               way   = i;
               found = 1'b1;
            end
         end
         if (found) begin
            if (counts[way] != falru_pkg::USE_MAX) counts[way] = counts[way] + USE_W'(1);
            stamps[way] = access_now;
            hits = bump48(hits);
         end else begin
            misses = bump48(misses);
            if (n < ENTRIES) begin
               way  = n;
               fill = n + 1;
            end else begin
               // oldest stamp loses, lowest slot wins a tie
               way = 0;
               for (int i = 1; i < ENTRIES; i++) begin
                  if (stamps[i] < stamps[way]) way = i;
               end
            end
            tags[way]   = page;
            counts[way] = USE_W'(1);
            stamps[way] = access_now;
         end
         r.hit        = found;
         r.slot       = way[SLOT_W-1:0];
         r.use_count  = counts[way];
         r.hit_total  = hits;
         r.miss_total = misses;
         r.filled     = fill[FILL_W-1:0];
         pending_lookups.push_back(r);
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare(string field, logic [STAMP_W-1:0] got, logic [STAMP_W-1:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
      endtask

      task check_result(lookup_result_type got);
         lookup_result_type want;
         if (pending_lookups.size() == 0) begin
            report($sformatf("unexpected transaction, slot %0d", got.slot));
            return;
         end
         want = pending_lookups.pop_front();
         compare("hit", got.hit, want.hit);
         compare("slot", got.slot, want.slot);
         compare("use_count", got.use_count, want.use_count);
         compare("hit_total", got.hit_total, want.hit_total);
         compare("miss_total", got.miss_total, want.miss_total);
         compare("filled", got.filled, want.filled);
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [PAGE_W-1:0] req_page = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_hit;
   logic [7:0]        rsp_slot;
   logic [30:0]       rsp_use_count;
   logic [47:0]       rsp_hit_total;
   logic [47:0]       rsp_miss_total;
   logic [8:0]        rsp_filled;

   lru_tracker_type tracker = new();

   int burst_left  = 0;
   int cycle_count = 0;
   int stall_mode  = 0;
   int stall_run   = 0;

   always #5 clock = ~clock;

   fully_associative_lru_cache_sim_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_page       (req_page),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_slot       (rsp_slot),
      .rsp_use_count  (rsp_use_count),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total),
      .rsp_filled     (rsp_filled)
   );

   task automatic send_page(logic [PAGE_W-1:0] page);
      req_valid <= 1'b1;
      req_page  <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_access(page);
   endtask

   // ends a burst now and then with a short or, rarely, a long gap
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   // result side: check accepted transactions, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result('{rsp_hit, rsp_slot, rsp_use_count,
                                rsp_hit_total, rsp_miss_total, rsp_filled});
      cycle_count++;
      if (cycle_count % 700 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: begin
            if (stall_run == 0 && $urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 8);
            rsp_stall <= (stall_run != 0);
            if (stall_run != 0) stall_run--;
         end
      endcase
   end

   initial begin
      logic [PAGE_W-1:0] corner_pages [DIRECTED_COUNT];
      logic [PAGE_W-1:0] pool [POOL_SIZE];
      logic [PAGE_W-1:0] page;
      int                hot_base;
      int                pick;

      corner_pages = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
         32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
         32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0001_0000, 32'h8000_0000,
         32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h1234_5678
      };
      for (int k = 0; k < POOL_SIZE; k++) pool[k] = $urandom;
      pool[0]  = '0;
      pool[1]  = '1;
      pool[2]  = 32'h8000_0000;
      hot_base = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_pages[k]) begin
         send_page(corner_pages[k]);
         pace();
      end
      drain();

      // moving hot window over a pool larger than the table: hits, fills and evictions
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 150 == 0) hot_base = (hot_base + $urandom_range(16, 96)) % POOL_SIZE;
         if (k % 500 == 250) drain();
         pick = $urandom_range(0, 99);
         if (pick < 8)
            page = $urandom;
         else if (pick < 70)
            page = pool[(hot_base + $urandom_range(0, HOT_SPAN - 1)) % POOL_SIZE];
         else
            page = pool[$urandom_range(0, POOL_SIZE - 1)];
         send_page(page);
         pace();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.outstanding() != 0)
         tracker.report($sformatf("%0d lookups never answered", tracker.outstanding()));
      if (tracker.errors == 0) begin
         $display("fully_associative_lru_cache_sim_core_tb: PASS");
      end else begin
         $display("fully_associative_lru_cache_sim_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("fully_associative_lru_cache_sim_core_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/falru_pkg.sv
rtl/fully_associative_lru_cache_sim_core.sv
rtl/falru_chk.sv
tb/fully_associative_lru_cache_sim_core_tb.sv
